// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/fdq_pkg.sv =====
// Shared types and constants for the decimating FIR filter.
package fdq_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_WORDS = 8;
    localparam int WORD_W     = 64;
    localparam int PADDR_W    = 6;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       emit;
    } fdq_entry_t;

endpackage

// ===== src/fdq_front.sv =====
// Front end: accepts input words and tags each with an emit flag taken from its decimation phase.
module fdq_front import fdq_pkg::*; #(
    parameter int DECIMATION = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       q_full,
    output logic                       push,
    output fdq_entry_t                 push_entry
);

    localparam int PH_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

    logic [PH_W-1:0] phase_reg;
    logic [PH_W-1:0] phase_next;

    assign in_ready          = !q_full;
    assign push              = in_valid && !q_full;
    assign push_entry.sample = sample_in;
    assign push_entry.emit   = (phase_reg == '0);

    always_comb
    begin
        phase_next = phase_reg;
        if (push)
        begin
            if (phase_reg == PH_W'(DECIMATION - 1))
                phase_next = '0;
            else
                phase_next = phase_reg + PH_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else
            phase_reg <= phase_next;
    end

endmodule

// ===== src/fdq_queue.sv =====
// Two-entry queue between the front end and the MAC engine.
`include "assert_macros.svh"
module fdq_queue import fdq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  fdq_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       nonempty,
    output fdq_entry_t pop_entry
);

    fdq_entry_t        mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign nonempty  = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    `ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full)
    `ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, nonempty)

endmodule

// ===== src/fdq_back.sv =====
// Back end: history line, shared MAC, rounding/saturation and output register.
`include "assert_macros.svh"
module fdq_back import fdq_pkg::*; #(
    parameter int TAP_COUNT = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          nonempty,
    input  fdq_entry_t                    pop_entry,
    output logic                          pop,
    input  logic [COEF_WORDS*WORD_W-1:0]  coef_bits,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_W-1:0]    sample_out
);

    localparam int IDX_W  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT + 1);
    localparam int SH_W   = ACC_W - 15;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           idx_next;
    logic signed [SAMPLE_W-1:0] hist_reg [TAP_COUNT];
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] out_data_reg;
    logic signed [SAMPLE_W-1:0] out_data_next;
    logic signed [COEF_W-1:0]   coef_sel;
    logic signed [SAMPLE_W-1:0] hist_sel;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic [SH_W-1:0]            shifted;
    logic [SH_W-16:0]           upper;
    logic                       fits;
    logic signed [SAMPLE_W-1:0] sat_val;
    logic                       out_free;
    logic                       last_tap;

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;
    assign out_free   = !out_valid_reg || out_ready;
    assign pop        = (state_reg == ST_IDLE) && nonempty;
    assign last_tap   = (idx_reg == IDX_W'(TAP_COUNT - 1));

    assign coef_sel  = coef_bits[COEF_W*int'(idx_reg) +: COEF_W];
    assign hist_sel  = hist_reg[idx_reg];
    assign prod_next = hist_sel * coef_sel;

    // +0.5 LSB then floor shift by 15; saturate when the top bits disagree
    assign acc_rnd = acc_reg + ACC_W'(1 << 14);
    assign shifted = acc_rnd[ACC_W-1:15];
    assign upper   = shifted[SH_W-1:15];
    assign fits    = (&upper) || !(|upper);
    assign sat_val = fits ? shifted[SAMPLE_W-1:0]
                   : (upper[SH_W-16] ? 16'sh8000 : 16'sh7fff);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop && pop_entry.emit)
                begin
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (idx_reg != '0)
                    acc_next = acc_reg + ACC_W'(prod_reg);
                if (last_tap)
                    state_next = ST_DRAIN;
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            ST_DRAIN:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_next  = sat_val;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TAP_COUNT; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                hist_reg[0] <= pop_entry.sample;
                for (int i = 1; i < TAP_COUNT; i++)
                    hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    `ASSERT_IMPL(a_out_from_done, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_DONE)
    `ASSERT_NEXT(a_idx_step, clk, rst_n, (state_reg == ST_MAC) && !last_tap, idx_reg == $past(idx_reg) + IDX_W'(1))

endmodule

// ===== src/fir_decimator_q15.sv =====
// Top level of the decimating Q15 FIR filter: config registers and block wiring.
//
// Input channel (in_valid/in_ready/sample_in) takes one signed Q15 word per
// handshake into a two-entry queue. The first word after reset and every
// DECIMATION-th word after it produces one output word on the
// out_valid/out_ready/sample_out channel; other words only update history.
// A non-emitting word only shifts the history; an emitting word also runs the
// single shared multiply-accumulate unit over all TAP_COUNT taps, and the
// engine takes no new word from the queue until that sum is in the output register.
// After an emitting word, the engine steps through the MAC, DRAIN and DONE
// states, then registers the result and raises out_valid.
// A stalled receiver holds the result in the output register; the engine
// finishes the next sum and waits, and the queue fills and deasserts in_ready.
// Reset clears history to zero, phase to zero and all coefficients to zero.
// Coefficients are written over APB, four 16-bit taps per 64-bit register,
// at byte address 8*i; write them only while the filter is idle.
module fir_decimator_q15 import fdq_pkg::*; #(
    parameter int TAP_COUNT  = 31,
    parameter int DECIMATION = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [WORD_W-1:0]          pwdata,
    output logic [WORD_W-1:0]          prdata,
    output logic                       pready
);

    logic [WORD_W-1:0]            coef_reg [COEF_WORDS];
    logic [COEF_WORDS*WORD_W-1:0] coef_bits;
    logic [2:0]                   reg_idx;
    logic                         push;
    fdq_entry_t                   push_entry;
    logic                         q_full;
    logic                         pop;
    logic                         nonempty;
    fdq_entry_t                   pop_entry;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign prdata  = coef_reg[reg_idx];

    always_comb
    begin
        for (int i = 0; i < COEF_WORDS; i++)
            coef_bits[i*WORD_W +: WORD_W] = coef_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_WORDS; i++)
                coef_reg[i] <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            coef_reg[reg_idx] <= pwdata;
        end
    end

    fdq_front #(
        .DECIMATION (DECIMATION)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    fdq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .nonempty   (nonempty),
        .pop_entry  (pop_entry)
    );

    fdq_back #(
        .TAP_COUNT (TAP_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .nonempty   (nonempty),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .coef_bits  (coef_bits),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

endmodule
